// ----- hdl/dle_frame_decoder_unit_assert.svh -----
// Assertion macros for the DLE frame decoder checker.
`ifndef DLE_FRAME_DECODER_UNIT_ASSERT_SVH
`define DLE_FRAME_DECODER_UNIT_ASSERT_SVH

// Clocked assertion, held off while reset is asserted.
`define DLED_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DLED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/dled_pkg.sv -----
// Shared types and constants for the DLE frame decoder.
package dled_pkg;

  localparam int MAX_FRAME_LEN = 4096;

  localparam logic [7:0] CH_STX     = 8'h02;
  localparam logic [7:0] CH_ETX     = 8'h03;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_DLE     = 8'h10;
  localparam logic [7:0] ESC_OFFSET = 8'h40;

  typedef enum logic [1:0] {
    ST_CONT  = 2'd0,
    ST_OK    = 2'd1,
    ST_ERR   = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_ESC_STX_ETX = 2'd0,
    REG_ESC_CR      = 2'd1,
    REG_MAX_LEN     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        esc_mode;
    logic        esc_cr;
    logic [12:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  decoded_byte;
    status_e     status;
    logic [12:0] frame_len;
    logic [13:0] resume_offset;
  } result_t;

endpackage

// ----- hdl/dled_core.sv -----
// Frame decoder state machine: one encoded byte per step.
module dled_core import dled_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] code_byte_i,
  input  logic       buffer_end_i,
  input  cfg_t       cfg_i,
  output logic       has_result_o,
  output result_t    result_o
);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_E_BODY = 3'd1,
    PH_E_ESC  = 3'd2,
    PH_N_STX  = 3'd3,
    PH_N_BODY = 3'd4,
    PH_N_ESC  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [12:0] out_cnt_q, out_cnt_d;
  logic [13:0] src_cnt_q, src_cnt_d;

  logic [12:0] cap;
  logic [12:0] out_inc;
  logic [13:0] src_inc;
  logic        do_put;
  logic [7:0]  put_val;
  logic        esc_ok;
  status_e     st;
  logic [13:0] res;
  logic [12:0] len;
  logic        bv;
  logic [7:0]  db;

  always_comb begin
    if (int'(cfg_i.max_len) > MAX_FRAME_LEN) begin
      cap = 13'(MAX_FRAME_LEN);
    end else begin
      cap = cfg_i.max_len;
    end
  end

  assign out_inc = out_cnt_q + 13'd1;
  assign src_inc = src_cnt_q + 14'd1;
  assign esc_ok  = (code_byte_i == CH_DLE) || (code_byte_i == CH_STX + ESC_OFFSET) ||
                   (code_byte_i == CH_ETX + ESC_OFFSET) ||
                   (cfg_i.esc_cr && (code_byte_i == CH_CR + ESC_OFFSET));

  always_comb begin
    phase_d   = phase_q;
    out_cnt_d = out_cnt_q;
    src_cnt_d = src_cnt_q;
    st        = ST_CONT;
    res       = '0;
    len       = '0;
    bv        = 1'b0;
    db        = '0;
    do_put    = 1'b0;
    put_val   = code_byte_i;

    unique case (phase_q)
      PH_E_BODY: begin
        if (code_byte_i == CH_DLE) begin
          src_cnt_d = src_inc;
          if (buffer_end_i) begin
            st  = ST_ERR;
            res = src_inc;
          end else begin
            phase_d = PH_E_ESC;
          end
        end else if (code_byte_i == CH_STX) begin
          st  = ST_ERR;
          res = src_cnt_q;
        end else if (code_byte_i == CH_ETX) begin
          st  = ST_OK;
          res = src_inc;
          len = out_cnt_q;
        end else begin
          src_cnt_d = src_inc;
          do_put    = 1'b1;
        end
      end
      PH_E_ESC: begin
        if (esc_ok) begin
          src_cnt_d = src_inc;
          phase_d   = PH_E_BODY;
          do_put    = 1'b1;
          if (code_byte_i != CH_DLE) begin
            put_val = code_byte_i - ESC_OFFSET;
          end
        end else begin
          st  = ST_ERR;
          res = src_inc;
        end
      end
      PH_N_STX: begin
        if (code_byte_i != CH_STX) begin
          st  = ST_ERR;
          res = 14'd1;
        end else begin
          src_cnt_d = 14'd2;
          if (buffer_end_i) begin
            st  = ST_ERR;
            res = 14'd2;
          end else begin
            phase_d = PH_N_BODY;
          end
        end
      end
      PH_N_BODY: begin
        if (code_byte_i == CH_DLE) begin
          if (buffer_end_i) begin
            st  = ST_ERR;
            res = src_cnt_q;
          end else begin
            src_cnt_d = src_inc;
            phase_d   = PH_N_ESC;
          end
        end else begin
          src_cnt_d = src_inc;
          do_put    = 1'b1;
        end
      end
      PH_N_ESC: begin
        if (code_byte_i == CH_DLE) begin
          src_cnt_d = src_inc;
          phase_d   = PH_N_BODY;
          do_put    = 1'b1;
        end else if (code_byte_i == CH_ETX) begin
          st  = ST_OK;
          res = src_inc;
          len = out_cnt_q;
        end else begin
          st  = ST_ERR;
          res = src_cnt_q - 14'd1;
        end
      end
      default: begin
        // start of a frame attempt; unused codes land here too
        phase_d   = PH_START;
        out_cnt_d = '0;
        src_cnt_d = '0;
        if (cfg_i.esc_mode) begin
          if (cap == 13'd0) begin
            st = ST_SHORT;
          end else if (code_byte_i != CH_STX) begin
            st = ST_ERR;
          end else begin
            src_cnt_d = 14'd1;
            if (buffer_end_i) begin
              st  = ST_ERR;
              res = 14'd1;
            end else begin
              phase_d = PH_E_BODY;
            end
          end
        end else begin
          if (cap < 13'd2) begin
            st = ST_SHORT;
          end else if (code_byte_i != CH_DLE) begin
            st = ST_ERR;
          end else begin
            src_cnt_d = 14'd1;
            if (buffer_end_i) begin
              st = ST_ERR;
            end else begin
              phase_d = PH_N_STX;
            end
          end
        end
      end
    endcase

    // payload byte: capacity check wins over buffer end
    if (do_put) begin
      bv        = 1'b1;
      db        = put_val;
      out_cnt_d = out_inc;
      if (out_inc >= cap) begin
        st  = ST_SHORT;
        res = '0;
      end else if (buffer_end_i) begin
        st  = ST_ERR;
        res = src_inc;
      end
    end

    if (st != ST_CONT) begin
      phase_d   = PH_START;
      out_cnt_d = '0;
      src_cnt_d = '0;
    end
  end

  assign has_result_o           = bv || (st != ST_CONT);
  assign result_o.byte_valid    = bv;
  assign result_o.decoded_byte  = db;
  assign result_o.status        = st;
  assign result_o.frame_len     = len;
  assign result_o.resume_offset = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      out_cnt_q <= '0;
      src_cnt_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      out_cnt_q <= out_cnt_d;
      src_cnt_q <= src_cnt_d;
    end
  end

endmodule

// ----- hdl/dle_frame_decoder_unit.sv -----
// DLE/STX/ETX frame decoder: top level with input, result and config registers.
// Takes one encoded byte per cycle on the slave stream, unless the result path
// stalls, and for each byte that yields a payload byte or ends the frame returns
// one word on the master stream via the input register, then the result register.
// Throughput is one byte per cycle while the receiver takes words; the decoder
// core steps once per byte and the result register lets a new byte enter while
// a result waits. After any status other than "continues" the decoder hunts
// for the next frame. Configuration writes take effect at once; the frame mode
// is latched at the start byte of each frame.
module dle_frame_decoder_unit import dled_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  // encoded byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic        s_axis_tlast,   // buffer_end
  // decoded stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] decoded_byte, [20:8] frame_len,
                                      // [34:21] resume_offset, [39:35] zero
  output logic [2:0]  m_axis_tuser    // [0] byte_valid, [2:1] status
);

  cfg_t        cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_end_q;
  logic        out_valid_q;
  result_t     out_q;

  logic        out_free;
  logic        step;
  logic        has_result;
  result_t     result;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.esc_mode <= 1'b1;
      cfg_q.esc_cr   <= 1'b1;
      cfg_q.max_len  <= 13'd4096;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ESC_STX_ETX: cfg_q.esc_mode <= cfg_data_i[0];
        REG_ESC_CR:      cfg_q.esc_cr   <= cfg_data_i[0];
        REG_MAX_LEN:     cfg_q.max_len  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  dled_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .code_byte_i  (in_byte_q),
    .buffer_end_i (in_end_q),
    .cfg_i        (cfg_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_result) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.resume_offset, out_q.frame_len, out_q.decoded_byte};
  assign m_axis_tuser  = {out_q.status, out_q.byte_valid};

endmodule

// ----- hdl/dled_chk.sv -----
// Port-level checker for the DLE frame decoder, bound to the top level.
`include "dle_frame_decoder_unit_assert.svh"

module dled_chk import dled_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // a stalled word holds
  `DLED_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
  // every word carries a byte or a status
  `DLED_ASSERT(a_no_empty, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tuser[0] || (m_axis_tuser[2:1] != ST_CONT), "empty output word")
  `DLED_ASSERT(a_byte_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0, "decoded byte set without byte_valid")
  `DLED_ASSERT(a_len_ok_only, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[2:1] != ST_OK) |-> m_axis_tdata[20:8] == 13'd0, "frame length outside ok status")
  `DLED_ASSERT(a_short_resume, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[2:1] == ST_SHORT) |-> m_axis_tdata[34:21] == 14'd0, "resume offset set on too-short status")

endmodule

bind dle_frame_decoder_unit dled_chk u_dled_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- sim/dle_frame_decoder_unit_tb.sv -----
// Self-checking testbench for the DLE frame decoder unit.
`timescale 1ns / 1ps

module dle_frame_decoder_unit_tb;
  import dled_pkg::*;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int SETTLE_CYCLES   = 4;    // result path is two registers deep
  localparam int DRAIN_CYCLES    = 10;
  localparam int PHASE_BYTES     = 60;
  localparam int NUM_PHASES      = 8;
  localparam int LONG_FRAME_LEN  = 48;

  typedef enum logic [2:0] {
    DP_HUNT,
    DP_E_BODY,
    DP_E_ESC,
    DP_N_STX,
    DP_N_BODY,
    DP_N_ESC
  } dec_phase_e;

  // Mirrors the decoder state, predicts the word each byte causes and checks
  // the decoded stream against it in order.
  class dle_decode_scoreboard;
    bit          esc_mode;
    bit          esc_cr;
    logic [12:0] max_len;
    dec_phase_e  phase;
    int          out_cnt;
    int          src_cnt;
    result_t     expected_words[$];
    int          errors;
    int          checked;
    int          n_ok;
    int          n_err;
    int          n_short;
    int          n_payload;

    function new();
      esc_mode = 1'b1;
      esc_cr   = 1'b1;
      max_len  = 13'd4096;
      restart();
    endfunction

    function void restart();
      phase   = DP_HUNT;
      out_cnt = 0;
      src_cnt = 0;
    endfunction

    function void apply_reg(reg_idx_e idx, logic [12:0] d);
      case (idx)
        REG_ESC_STX_ETX: esc_mode = d[0];
        REG_ESC_CR:      esc_cr   = d[0];
        REG_MAX_LEN:     max_len  = d;
        default: ;
      endcase
    endfunction

    function void note_code_byte(logic [7:0] b, logic last);
      int          cap;
      bit          valid;
      logic [7:0]  db;
      status_e     st;
      int          res;
      int          len;
      result_t     w;
      cap   = (max_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : int'(max_len);
      valid = 1'b0;
      db    = 8'h00;
      st    = ST_CONT;
      res   = 0;
      len   = 0;
      case (phase)
        DP_E_BODY: begin
          if (b == CH_DLE) begin
            src_cnt++;
            if (last) begin
              st = ST_ERR; res = src_cnt;
            end else begin
              phase = DP_E_ESC;
            end
          end else if (b == CH_STX) begin
            st = ST_ERR; res = src_cnt;
          end else if (b == CH_ETX) begin
            st = ST_OK; res = src_cnt + 1; len = out_cnt;
          end else begin
            src_cnt++; valid = 1'b1; db = b;
          end
        end
        DP_E_ESC: begin
          if (b == CH_DLE || b == CH_STX + ESC_OFFSET || b == CH_ETX + ESC_OFFSET ||
              (esc_cr && b == CH_CR + ESC_OFFSET)) begin
            src_cnt++;
            phase = DP_E_BODY;
            valid = 1'b1;
            db    = (b == CH_DLE) ? b : b - ESC_OFFSET;
          end else begin
            st = ST_ERR; res = src_cnt + 1;
          end
        end
        DP_N_STX: begin
          if (b != CH_STX) begin
            st = ST_ERR; res = 1;
          end else begin
            src_cnt = 2;
            if (last) begin
              st = ST_ERR; res = 2;
            end else begin
              phase = DP_N_BODY;
            end
          end
        end
        DP_N_BODY: begin
          if (b == CH_DLE) begin
            if (last) begin
              st = ST_ERR; res = src_cnt;
            end else begin
              src_cnt++; phase = DP_N_ESC;
            end
          end else begin
            src_cnt++; valid = 1'b1; db = b;
          end
        end
        DP_N_ESC: begin
          if (b == CH_DLE) begin
            src_cnt++; phase = DP_N_BODY; valid = 1'b1; db = b;
          end else if (b == CH_ETX) begin
            st = ST_OK; res = src_cnt + 1; len = out_cnt;
          end else begin
            st = ST_ERR; res = src_cnt - 1;
          end
        end
        default: begin
          restart();
          if (esc_mode) begin
            if (cap < 1) begin
              st = ST_SHORT;
            end else if (b != CH_STX) begin
              st = ST_ERR;
            end else begin
              src_cnt = 1;
              if (last) begin
                st = ST_ERR; res = 1;
              end else begin
                phase = DP_E_BODY;
              end
            end
          end else begin
            if (cap < 2) begin
              st = ST_SHORT;
            end else if (b != CH_DLE) begin
              st = ST_ERR;
            end else begin
              src_cnt = 1;
              if (last) st = ST_ERR;
              else phase = DP_N_STX;
            end
          end
        end
      endcase

      // payload byte: capacity check wins over a buffer end on the same byte
      if (valid) begin
        out_cnt = (out_cnt + 1) & 32'h1FFF;
        n_payload++;
        if (out_cnt >= cap) begin
          st = ST_SHORT; res = 0;
        end else if (last) begin
          st = ST_ERR; res = src_cnt;
        end
      end

      if (st != ST_CONT) restart();
      case (st)
        ST_OK:    n_ok++;
        ST_ERR:   n_err++;
        ST_SHORT: n_short++;
        default: ;
      endcase
      if (valid || st != ST_CONT) begin
        w.byte_valid    = valid;
        w.decoded_byte  = db;
        w.status        = st;
        w.frame_len     = len[12:0];
        w.resume_offset = res[13:0];
        expected_words.push_back(w);
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    task check_decoded_word(result_t got);
      result_t exp;
      checked++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d unexpected (status %0d, byte %02h)",
                                  checked, got.status, got.decoded_byte));
        return;
      end
      exp = expected_words.pop_front();
      if (got.byte_valid !== exp.byte_valid)
        report_mismatch($sformatf("word %0d byte_valid %b, want %b",
                                  checked, got.byte_valid, exp.byte_valid));
      if (got.decoded_byte !== exp.decoded_byte)
        report_mismatch($sformatf("word %0d decoded_byte %02h, want %02h",
                                  checked, got.decoded_byte, exp.decoded_byte));
      if (got.status !== exp.status)
        report_mismatch($sformatf("word %0d status %0d, want %0d",
                                  checked, got.status, exp.status));
      if (got.frame_len !== exp.frame_len)
        report_mismatch($sformatf("word %0d frame_len %0d, want %0d",
                                  checked, got.frame_len, exp.frame_len));
      if (got.resume_offset !== exp.resume_offset)
        report_mismatch($sformatf("word %0d resume_offset %0d, want %0d",
                                  checked, got.resume_offset, exp.resume_offset));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] code_byte
  logic        s_axis_tlast;   // buffer_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [7:0] decoded_byte, [20:8] frame_len,
                               // [34:21] resume_offset, [39:35] zero
  logic [2:0]  m_axis_tuser;   // [0] byte_valid, [2:1] status

  dle_frame_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  dle_decode_scoreboard sb;
  logic [8:0] enc_stream[$];   // [8] buffer_end, [7:0] code_byte
  bit   cur_esc;
  bit   cur_cr;
  bit   quiet;
  int   gap_pct;
  int   stall_pct;
  int   stall_left;
  int   idle_cycles;
  int   bytes_sent;
  int   cfg_writes;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // handshake monitor: predicts on accepted bytes, checks accepted words
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        sb.apply_reg(reg_idx_e'(cfg_index_i), cfg_data_i);
        cfg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) sb.note_code_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_valid    = m_axis_tuser[0];
        got.status        = status_e'(m_axis_tuser[2:1]);
        got.decoded_byte  = m_axis_tdata[7:0];
        got.frame_len     = m_axis_tdata[20:8];
        got.resume_offset = m_axis_tdata[34:21];
        sb.check_decoded_word(got);
      end
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake in %0d cycles, %0d words outstanding",
                   WATCHDOG_LIMIT, sb.expected_words.size());
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!quiet && stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready = 1'b0;
        stall_left    = $urandom_range(1, 10) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_stream();
    logic [8:0] w;
    while (enc_stream.size() != 0) begin
      w = enc_stream.pop_front();
      send_byte(w[7:0], w[8]);
    end
  endtask

  task automatic program_reg(reg_idx_e idx, logic [12:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // wait for the decoder to drain before touching its registers
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(bit esc, bit cr, logic [12:0] len);
    logic [12:0] d;
    d = 13'($urandom); d[0] = esc;   // upper bits are don't-care for 1-bit registers
    program_reg(REG_ESC_STX_ETX, d);
    d = 13'($urandom); d[0] = cr;
    program_reg(REG_ESC_CR, d);
    program_reg(REG_MAX_LEN, len);
    cur_esc = esc;
    cur_cr  = cr;
  endtask

  function automatic void push_enc(logic [7:0] b, logic last = 1'b0);
    enc_stream.push_back({last, b});
  endfunction

  function automatic void push_payload(logic [7:0] p);
    if (p == CH_DLE) begin
      push_enc(CH_DLE); push_enc(CH_DLE);
    end else if (cur_esc &&
                 (p == CH_STX || p == CH_ETX || (p == CH_CR && cur_cr && $urandom_range(0, 1)))) begin
      push_enc(CH_DLE); push_enc(p + ESC_OFFSET);
    end else begin
      push_enc(p);
    end
  endfunction

  function automatic logic [7:0] pick_payload();
    logic [7:0] specials [9];
    specials = '{CH_DLE, CH_STX, CH_ETX, CH_CR, 8'h42, 8'h43, 8'h4D, 8'h00, 8'hFF};
    if ($urandom_range(0, 2) == 0) return specials[$urandom_range(0, 8)];
    return 8'($urandom);
  endfunction

  // one frame in the current mode; a damaged one gets a changed, missing or
  // extra byte, or is cut short by a buffer end
  function automatic void build_frame(int n, bit damage);
    int s;
    int k;
    s = enc_stream.size();
    if (cur_esc) begin
      push_enc(CH_STX);
    end else begin
      push_enc(CH_DLE); push_enc(CH_STX);
    end
    for (int i = 0; i < n; i++) push_payload(pick_payload());
    if (!cur_esc) push_enc(CH_DLE);
    push_enc(CH_ETX, $urandom_range(0, 3) == 0);
    if (damage) begin
      k = $urandom_range(0, enc_stream.size() - s - 1);
      case ($urandom_range(0, 3))
        0: enc_stream[s + k][7:0] = pick_payload();
        1: begin
          enc_stream[s + k][8] = 1'b1;
          while (enc_stream.size() > s + k + 1) void'(enc_stream.pop_back());
        end
        2: enc_stream.insert(s + k, {1'b0, pick_payload()});
        default: enc_stream.delete(s + k);
      endcase
    end
  endfunction

  function automatic void add_traffic();
    int r;
    int n;
    r = $urandom_range(0, 9);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    if (r == 0) begin
      repeat ($urandom_range(1, 3)) push_enc(8'($urandom), 1'($urandom_range(0, 1)));
    end else begin
      build_frame(n, r <= 2);
    end
  endfunction

  task automatic run_phase(int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      add_traffic();
      send_stream();
    end
  endtask

  initial begin
    bit          ph_esc [NUM_PHASES] = '{1, 1, 0, 0, 1, 0, 1, 0};
    bit          ph_cr  [NUM_PHASES] = '{1, 0, 1, 0, 1, 1, 0, 0};
    int          ph_len [NUM_PHASES] = '{4096, 5, 8191, 3, 0, 1, 1, 2};
    int          pct    [4]          = '{0, 10, 30, 60};
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ESC_STX_ETX;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    idle_cycles   = 0;
    bytes_sent    = 0;
    cfg_writes    = 0;
    quiet         = 1'b0;
    gap_pct       = 20;
    stall_pct     = 20;
    cur_esc       = 1'b1;
    cur_cr        = 1'b1;
    sb            = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // escaped mode out of reset: every escape, byte extremes, then error cases
    push_enc(CH_STX); push_enc(8'h00); push_enc(8'hFF);
    push_enc(CH_DLE); push_enc(CH_DLE);
    push_enc(CH_DLE); push_enc(CH_STX + ESC_OFFSET);
    push_enc(CH_DLE); push_enc(CH_ETX + ESC_OFFSET);
    push_enc(CH_DLE); push_enc(CH_CR + ESC_OFFSET);
    push_enc(CH_ETX);
    push_enc(8'h55);                                   // bad start byte
    push_enc(CH_STX); push_enc(CH_DLE); push_enc(8'h20); // bad escape
    push_enc(CH_STX); push_enc(8'h41); push_enc(CH_STX); // start inside frame
    send_stream();

    // plain mode: escape of a non-DLE byte, buffer end right after first DLE
    settle();
    set_config(1'b0, 1'b1, 13'd4096);
    push_enc(CH_DLE); push_enc(CH_STX); push_enc(CH_DLE); push_enc(8'h41);
    push_enc(CH_DLE, 1'b1);
    send_stream();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      set_config(ph_esc[ph], ph_cr[ph], 13'(ph_len[ph]));
      gap_pct   = pct[$urandom_range(0, 3)];
      stall_pct = pct[$urandom_range(0, 3)];
      run_phase(PHASE_BYTES);
      // sometimes leave a frame open across the next register writes
      if ($urandom_range(0, 1)) begin
        build_frame($urandom_range(2, 8), 1'b0);
        repeat ($urandom_range(1, 3)) void'(enc_stream.pop_back());
        send_stream();
      end
    end

    // a longer plain frame with the length setting above the frame limit
    settle();
    set_config(1'b0, 1'b0, 13'd8191);
    gap_pct   = 10;
    stall_pct = 10;
    push_enc(CH_DLE); push_enc(CH_STX);
    for (int i = 0; i < LONG_FRAME_LEN; i++) push_payload(8'($urandom));
    push_enc(CH_DLE); push_enc(CH_ETX);
    send_stream();

    // final stretch at full rate on both sides
    settle();
    quiet = 1'b1;
    set_config(1'b1, 1'b1, 13'd4096);
    run_phase(60);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_words.size() != 0)
      sb.report_mismatch($sformatf("%0d expected words never arrived",
                                   sb.expected_words.size()));

    $display("run: %0d code bytes in both framing modes over %0d register writes",
             bytes_sent, cfg_writes);
    $display("run: %0d words checked, %0d payload bytes, %0d ok, %0d error, %0d too short",
             sb.checked, sb.n_payload, sb.n_ok, sb.n_err, sb.n_short);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
